@@ rtl/core/afd_pkg.sv @@
// Shared types, codes and constants for the API frame framer and deframer.
package afd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 256;
  localparam int unsigned HDR_LEN         = 5;

  localparam logic [7:0] SOF_BYTE    = 8'h7E;
  localparam logic [7:0] API_ID      = 8'h01;
  localparam logic [7:0] FRAME_ID    = 8'h00;
  localparam logic [7:0] OPTIONS     = 8'h00;
  localparam logic [7:0] CSUM_TARGET = 8'hFF;

  typedef enum logic [1:0] {
    OP_TX      = 2'd0,
    OP_RX      = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_RX_DATA = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_CSUM_ERR  = 3'd2,
    ST_SHORT     = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_LENHI = 3'd1,
    PH_LENLO = 3'd2,
    PH_BODY  = 3'd3,
    PH_CSUM  = 3'd4
  } rx_phase_t;

  // Position of a line byte within a transmitted frame
  typedef enum logic [3:0] {
    POS_SOF    = 4'd0,
    POS_LENHI  = 4'd1,
    POS_LENLO  = 4'd2,
    POS_API    = 4'd3,
    POS_FID    = 4'd4,
    POS_ADDRHI = 4'd5,
    POS_ADDRLO = 4'd6,
    POS_OPT    = 4'd7,
    POS_DATA   = 4'd8,
    POS_CSUM   = 4'd9
  } tx_pos_t;

  // What one transmit word leaves for the emitter
  typedef struct packed {
    logic        hdr;
    logic        csum_en;
    logic [15:0] flen;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  csum;
  } tx_desc_t;

  // The single result a receive or timeout word may cause
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
  } rx_res_t;

endpackage

@@ rtl/core/afd_tx.sv @@
// Transmit framer state: remaining payload count, running body sum, frame descriptor.
module afd_tx #(
  parameter int unsigned MAX_PAYLOAD = afd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tx_en,
  input  logic [7:0]       data_byte,
  input  logic [15:0]      dest_address,
  input  logic [8:0]       payload_length,
  output afd_pkg::tx_desc_t desc
);
  import afd_pkg::*;

  localparam int unsigned RW = $clog2(MAX_PAYLOAD + 1);

  logic [RW-1:0] tx_remaining_r, tx_remaining_nxt;
  logic [7:0]    tx_sum_r, tx_sum_nxt;
  logic          start;
  logic [16:0]   n17;
  logic [RW-1:0] n_cur;
  logic [7:0]    sum_base;
  logic [7:0]    sum_new;

  always_comb begin
    start = (tx_remaining_r == '0);
    // clamp the frame length to one .. MAX_PAYLOAD
    if (payload_length == 9'd0) begin
      n17 = 17'd1;
    end else if (17'(payload_length) > 17'(MAX_PAYLOAD)) begin
      n17 = 17'(MAX_PAYLOAD);
    end else begin
      n17 = 17'(payload_length);
    end
    n_cur    = start ? n17[RW-1:0] : tx_remaining_r;
    sum_base = start ? 8'(API_ID + FRAME_ID + dest_address[15:8] + dest_address[7:0] + OPTIONS)
                     : tx_sum_r;
    sum_new  = sum_base + data_byte;
    tx_remaining_nxt = n_cur - RW'(1);
    tx_sum_nxt       = sum_new;

    desc.hdr     = start;
    desc.csum_en = (tx_remaining_nxt == '0);
    desc.flen    = 16'(n17 + 17'(HDR_LEN));
    desc.addr    = dest_address;
    desc.data    = data_byte;
    desc.csum    = CSUM_TARGET - sum_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_remaining_r <= '0;
      tx_sum_r       <= '0;
    end else if (tx_en) begin
      tx_remaining_r <= tx_remaining_nxt;
      tx_sum_r       <= tx_sum_nxt;
    end
  end

endmodule

@@ rtl/core/afd_rx.sv @@
// Receive deframer: start, length, body and checksum phases with status reporting.
module afd_rx (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rx_en,
  input  logic             tmo_en,
  input  logic [7:0]       data_byte,
  output afd_pkg::rx_res_t res
);
  import afd_pkg::*;

  rx_phase_t   phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  sum_add;
  logic [15:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    sum_add    = sum_r + data_byte;
    cnt_inc    = cnt_r + 16'd1;
    res.valid  = 1'b0;
    res.kind   = KIND_STATUS;
    res.data   = 8'h00;
    res.status = ST_OK;

    if (tmo_en) begin
      res.valid  = 1'b1;
      res.status = ST_TIMEOUT;
      phase_nxt  = PH_START;
      cnt_nxt    = '0;
      sum_nxt    = '0;
    end else if (rx_en) begin
      case (phase_r)
        PH_START: begin
          if (data_byte == SOF_BYTE) begin
            phase_nxt = PH_LENHI;
            len_nxt   = '0;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            res.valid  = 1'b1;
            res.status = ST_BAD_START;
          end
        end
        PH_LENHI: begin
          len_nxt   = {data_byte, 8'h00};
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_nxt = {len_r[15:8], data_byte};
          cnt_nxt = '0;
          sum_nxt = '0;
          if ({len_r[15:8], data_byte} < 16'(HDR_LEN)) begin
            res.valid  = 1'b1;
            res.status = ST_SHORT;
            phase_nxt  = PH_START;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_inc;
          // header bytes are counted and summed but not passed on
          if (cnt_inc > 16'(HDR_LEN)) begin
            res.valid = 1'b1;
            res.kind  = KIND_RX_DATA;
            res.data  = data_byte;
          end
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CSUM;
          end
        end
        PH_CSUM: begin
          sum_nxt    = sum_add;
          res.valid  = 1'b1;
          res.status = (sum_add == CSUM_TARGET) ? ST_OK : ST_CSUM_ERR;
          phase_nxt  = PH_START;
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/api_frame_framer_deframer.sv @@
// Top level of the API frame framer and deframer with result sequencer and output register.
//
//  channel | direction | tdata                                   | tuser       | tlast
//  --------+-----------+-----------------------------------------+-------------+-----------
//  in_     | slave     | data_byte, dest_address, payload_length | opcode      | -
//  out_    | master    | out_byte, status                        | kind        | last
//
// Flow: a word that causes at most one result is taken every cycle while out_tready
// is high. The first transmit word of a frame yields the header and its data byte,
// and the checksum too when the frame holds one byte; the last transmit word yields
// its data byte and the checksum, each in turn through the single result register.
// Reset: synchronous, active low; clears the framer, deframer and sequencer at once.
// Stalls: out_tready low holds the result register; in_tready drops while the
// results of the word in the sequencer are still to be moved out.
module api_frame_framer_deframer #(
  parameter int unsigned MAX_PAYLOAD = afd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [23:8] dest_address, [32:24] payload_length
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last result of the input word
);
  import afd_pkg::*;

  logic        in_acc;
  logic        tx_en, rx_en, tmo_en;
  tx_desc_t    tx_desc;
  rx_res_t     rx_res;

  // sequencer: the word whose results are being moved out
  logic        w_valid_r, w_valid_nxt;
  logic        w_tx_r;
  tx_desc_t    w_desc_r;
  rx_res_t     w_rx_r;
  tx_pos_t     w_pos_r, w_pos_nxt;
  logic        w_last;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  status_t     out_status_r;
  kind_t       out_kind_r;
  logic        out_last_r;
  logic        out_ld;

  logic [7:0]  seq_byte;
  status_t     seq_status;
  kind_t       seq_kind;

  assign in_acc = in_tvalid && in_tready;
  assign tx_en  = in_acc && (opcode_t'(in_tuser) == OP_TX);
  assign rx_en  = in_acc && (opcode_t'(in_tuser) == OP_RX);
  assign tmo_en = in_acc && (opcode_t'(in_tuser) == OP_TIMEOUT);

  afd_tx #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .tx_en         (tx_en),
    .data_byte     (in_tdata[7:0]),
    .dest_address  (in_tdata[23:8]),
    .payload_length(in_tdata[32:24]),
    .desc          (tx_desc)
  );

  afd_rx u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_en    (rx_en),
    .tmo_en   (tmo_en),
    .data_byte(in_tdata[7:0]),
    .res      (rx_res)
  );

  // Pick the result at the current sequencer position
  always_comb begin
    seq_byte   = 8'h00;
    seq_status = ST_OK;
    seq_kind   = KIND_TX;
    w_last     = 1'b1;
    if (w_tx_r) begin
      w_last = (w_pos_r == POS_CSUM) || ((w_pos_r == POS_DATA) && !w_desc_r.csum_en);
      case (w_pos_r)
        POS_SOF:    seq_byte = SOF_BYTE;
        POS_LENHI:  seq_byte = w_desc_r.flen[15:8];
        POS_LENLO:  seq_byte = w_desc_r.flen[7:0];
        POS_API:    seq_byte = API_ID;
        POS_FID:    seq_byte = FRAME_ID;
        POS_ADDRHI: seq_byte = w_desc_r.addr[15:8];
        POS_ADDRLO: seq_byte = w_desc_r.addr[7:0];
        POS_OPT:    seq_byte = OPTIONS;
        POS_DATA:   seq_byte = w_desc_r.data;
        POS_CSUM:   seq_byte = w_desc_r.csum;
        default:    seq_byte = 8'h00;
      endcase
    end else begin
      seq_byte   = w_rx_r.data;
      seq_status = w_rx_r.status;
      seq_kind   = w_rx_r.kind;
    end
  end

  // Advance the result register whenever it is empty or being drained
  assign out_ld    = w_valid_r && (!out_valid_r || out_tready);
  // Take a new word once the last result of the current one moves out
  assign in_tready = !w_valid_r || (out_ld && w_last);

  always_comb begin
    w_valid_nxt = w_valid_r;
    w_pos_nxt   = w_pos_r;
    if (out_ld) begin
      if (w_last) begin
        w_valid_nxt = 1'b0;
      end else begin
        w_pos_nxt = tx_pos_t'(w_pos_r + 4'd1);
      end
    end
    if (tx_en) begin
      w_valid_nxt = 1'b1;
      w_pos_nxt   = tx_desc.hdr ? POS_SOF : POS_DATA;
    end else if (rx_en || tmo_en) begin
      w_valid_nxt = rx_res.valid;
    end
    out_valid_nxt = out_ld ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      w_valid_r   <= w_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: load the sequencer on accept, the result register on advance
  always_ff @(posedge clk) begin
    w_pos_r <= w_pos_nxt;
    if (in_acc) begin
      w_tx_r   <= tx_en;
      w_desc_r <= tx_desc;
      w_rx_r   <= rx_res;
    end
    if (out_ld) begin
      out_byte_r   <= seq_byte;
      out_status_r <= seq_status;
      out_kind_r   <= seq_kind;
      out_last_r   <= w_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/afd_checker.sv @@
// Port-level checks on the framer and deframer, bound to the top level.
module afd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import afd_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A status is always the sole result of its word
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_STATUS) |-> out_tlast)
    else $error("status not marked last");

  // A received payload byte is always the sole result of its word
  a_rxdata_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_RX_DATA) |-> out_tlast)
    else $error("received byte not marked last");

  // Byte words carry no status
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == KIND_TX) || (out_tuser == KIND_RX_DATA))
      |-> out_tdata[10:8] == ST_OK)
    else $error("status set on a byte word");

  // Status words carry a zero byte
  a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_STATUS) |-> out_tdata[7:0] == 8'h00)
    else $error("byte set on a status word");

endmodule

bind api_frame_framer_deframer afd_checker u_afd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
